/* src/lctp_pkg.sv */
// Package for the least-cost transport plan unit: sizes, op codes,
// sequencer states. No dependencies; lctp_if, the top level and the testbench use it.
`default_nettype none

package lctp_pkg;

	localparam int NUM_SOURCES = 4;
	localparam int NUM_SINKS   = 4;
	localparam int NUM_CELLS   = NUM_SOURCES * NUM_SINKS;

	localparam int ROW_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int COL_W  = (NUM_SINKS > 1) ? $clog2(NUM_SINKS) : 1;
	localparam int CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	localparam int IDX_W  = 3;
	localparam int VAL_W  = 20;
	localparam int LIM_W  = 17;
	localparam int PROD_W = VAL_W + LIM_W;
	localparam int TOT_W  = 47;

	localparam logic [LIM_W-1:0] COST_LIMIT = LIM_W'(100000);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [TOT_W-1:0] tot_t;

	typedef enum logic [1:0] {
		OP_SUPPLY = 2'd0,
		OP_DEMAND = 2'd1,
		OP_COST   = 2'd2,
		OP_SOLVE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_SCAN_END,
		S_ALLOC,
		S_ACC,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	// one more state than fits above would overflow; emit wait gets its own code
	typedef enum logic [1:0] {
		E_NONE,
		E_WAIT
	} emit_t;

endpackage

`default_nettype wire

/* src/lctp_if.sv */
// Channel interfaces of the least-cost transport plan unit: command input
// and plan-cell output, each with valid/ready. Depends on lctp_pkg.
`default_nettype none

interface lctp_cmd_if;
	logic             valid;
	logic             ready;
	lctp_pkg::op_t    op;
	lctp_pkg::idx_t   row_index;
	lctp_pkg::idx_t   col_index;
	lctp_pkg::val_t   value;

	modport source (output valid, op, row_index, col_index, value, input ready);
	modport sink   (input valid, op, row_index, col_index, value, output ready);
endinterface

interface lctp_plan_if;
	logic             valid;
	logic             ready;
	lctp_pkg::idx_t   out_row;
	lctp_pkg::idx_t   out_col;
	lctp_pkg::val_t   amount;
	lctp_pkg::tot_t   total_cost;
	logic             last;

	modport source (output valid, out_row, out_col, amount, total_cost, last, input ready);
	modport sink   (input valid, out_row, out_col, amount, total_cost, last, output ready);
endinterface

`default_nettype wire

/* src/lctp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the cost matrix and the plan. No package dependencies.
`default_nettype none

module lctp_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 20,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wa,
	input  wire logic [WIDTH-1:0] wd,
	input  wire logic [AW-1:0]    ra,
	output logic      [WIDTH-1:0] rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd <= mem[ra];
	end

endmodule

`default_nettype wire

/* src/least_cost_transport_plan_unit.sv */
// Top level of the least-cost transport plan unit: command decode, solve
// sequencer, remainders and output register. Depends on lctp_pkg, lctp_if, lctp_ram.
`default_nettype none

// Supply, demand and unit-cost load commands are taken one per cycle and
// produce no output. A solve command builds the plan by the least-cost
// method and then streams every plan cell in row-major order; the last
// transfer carries the total cost. While a solve runs the command channel
// is held not ready. A solve starts with a setup step; each allocation pass then
// scans the cost memory one cell per cycle through its single read port, makes
// the final compare, writes the allocation and accumulates the cost; there are at
// most NUM_SOURCES + NUM_SINKS - 1 allocating passes and one final empty scan.
// Each plan cell then goes through a plan memory read, an output load and a
// transfer, which may be held by an output stall. Loaded values persist across
// solves; the plan is cleared at the start of each solve.
module least_cost_transport_plan_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lctp_cmd_if.sink   cmd,
	lctp_plan_if.source plan
);
	import lctp_pkg::*;

	state_t state_q, state_nx;
	emit_t  emit_q;

	// stored loads
	val_t supply_q [NUM_SOURCES];
	val_t demand_q [NUM_SINKS];

	// working remainders (written at solve start, no reset needed)
	val_t rs_q [NUM_SOURCES];
	val_t rd_q [NUM_SINKS];
	logic [NUM_SOURCES-1:0] rs_act;
	logic [NUM_SINKS-1:0]   rd_act;

	// plan valid bits stand for the per-solve clear of the plan memory
	logic [NUM_CELLS-1:0] plan_vld_q;

	// cost valid bits: a cost entry never loaded since reset reads as zero
	logic [NUM_CELLS-1:0] cost_vld_q;

	// scan counters and read pipeline
	logic [CELL_W-1:0] scan_idx_q;
	logic [ROW_W-1:0]  scan_row_q;
	logic [COL_W-1:0]  scan_col_q;
	logic              scan_vld_s1;
	logic [CELL_W-1:0] scan_idx_s1;
	logic [ROW_W-1:0]  scan_row_s1;
	logic [COL_W-1:0]  scan_col_s1;

	// best candidate of the current pass
	logic              found_q;
	logic [LIM_W-1:0]  best_q;
	logic [ROW_W-1:0]  br_q;
	logic [COL_W-1:0]  bc_q;
	logic [CELL_W-1:0] bk_q;
	logic              hit;
	logic              found_nx;

	// allocation and accumulation
	val_t              rs_sel, rd_sel, alloc_amt;
	logic [PROD_W-1:0] prod_q;
	tot_t              total_q;

	// emit counters
	logic [CELL_W-1:0] emit_idx_q;
	logic [ROW_W-1:0]  emit_row_q;
	logic [COL_W-1:0]  emit_col_q;
	logic              emit_last;

	// output register
	logic [ROW_W-1:0]  o_row_q;
	logic [COL_W-1:0]  o_col_q;
	val_t              o_amt_q;
	tot_t              o_tot_q;
	logic              o_last_q;

	// control strobes
	logic cmd_xfer, plan_xfer;
	logic ld_supply, ld_demand, ld_cost;
	logic do_init, do_scan, do_restart, do_alloc, do_acc, do_emit_ld;

	// memory ports
	logic [CELL_W-1:0] cost_wa;
	val_t              cost_rd;
	val_t              cost_use;
	val_t              plan_rd;

	lctp_ram #(.DEPTH(NUM_CELLS), .WIDTH(VAL_W), .AW(CELL_W)) u_cost_ram (
		.clk (clk),
		.we  (ld_cost),
		.wa  (cost_wa),
		.wd  (cmd.value),
		.ra  (scan_idx_q),
		.rd  (cost_rd)
	);

	lctp_ram #(.DEPTH(NUM_CELLS), .WIDTH(VAL_W), .AW(CELL_W)) u_plan_ram (
		.clk (clk),
		.we  (do_alloc),
		.wa  (bk_q),
		.wd  (alloc_amt),
		.ra  (emit_idx_q),
		.rd  (plan_rd)
	);

	// ---------------- command decode ----------------
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign plan_xfer = plan.valid && plan.ready;

	// drop loads whose index falls outside the configured table
	assign ld_supply = cmd_xfer && (cmd.op == OP_SUPPLY) && (32'(cmd.row_index) < NUM_SOURCES);
	assign ld_demand = cmd_xfer && (cmd.op == OP_DEMAND) && (32'(cmd.col_index) < NUM_SINKS);
	assign ld_cost   = cmd_xfer && (cmd.op == OP_COST)
	                   && (32'(cmd.row_index) < NUM_SOURCES)
	                   && (32'(cmd.col_index) < NUM_SINKS);
	assign cost_wa   = CELL_W'(32'(cmd.row_index) * NUM_SINKS + 32'(cmd.col_index));

	// ---------------- scan compare ----------------
	always_comb begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			rs_act[i] = (rs_q[i] != '0);
		end
		for (int j = 0; j < NUM_SINKS; j++) begin
			rd_act[j] = (rd_q[j] != '0);
		end
	end

	assign cost_use = cost_vld_q[scan_idx_s1] ? cost_rd : '0;

	// strict less-than keeps the first cell in row-major order on ties
	assign hit = scan_vld_s1 && rs_act[scan_row_s1] && rd_act[scan_col_s1]
	             && (cost_use < VAL_W'(best_q));
	assign found_nx = found_q || hit;

	// ---------------- allocation ----------------
	assign rs_sel    = rs_q[br_q];
	assign rd_sel    = rd_q[bc_q];
	assign alloc_amt = (rs_sel < rd_sel) ? rs_sel : rd_sel;

	assign emit_last = (emit_idx_q == CELL_W'(NUM_CELLS - 1));

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_xfer && (cmd.op == OP_SOLVE)) begin
					state_nx = S_INIT;
				end
			end
			S_INIT: state_nx = S_SCAN;
			S_SCAN: begin
				if (scan_idx_q == CELL_W'(NUM_CELLS - 1)) begin
					state_nx = S_SCAN_END;
				end
			end
			S_SCAN_END: state_nx = found_nx ? S_ALLOC : S_EMIT_RD;
			S_ALLOC:    state_nx = S_ACC;
			S_ACC:      state_nx = S_SCAN;
			S_EMIT_RD:  state_nx = S_EMIT_LD;
			S_EMIT_LD: begin
				// hold here while the loaded cell waits for its transfer
				if (emit_q == E_WAIT && plan_xfer) begin
					state_nx = emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		do_init    = 1'b0;
		do_scan    = 1'b0;
		do_restart = 1'b0;
		do_alloc   = 1'b0;
		do_acc     = 1'b0;
		do_emit_ld = 1'b0;
		case (state_q)
			S_INIT: begin
				do_init    = 1'b1;
				do_restart = 1'b1;
			end
			S_SCAN:    do_scan  = 1'b1;
			S_ALLOC:   do_alloc = 1'b1;
			S_ACC: begin
				do_acc     = 1'b1;
				do_restart = 1'b1;
			end
			S_EMIT_LD: do_emit_ld = (emit_q == E_NONE);
			default: ;
		endcase
	end

	assign plan.valid = (state_q == S_EMIT_LD) && (emit_q == E_WAIT);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			emit_q      <= E_NONE;
			scan_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			scan_idx_q  <= '0;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			emit_idx_q  <= '0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			plan_vld_q  <= '0;
			cost_vld_q  <= '0;
			total_q     <= '0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				supply_q[i] <= '0;
			end
			for (int j = 0; j < NUM_SINKS; j++) begin
				demand_q[j] <= '0;
			end
		end else begin
			state_q     <= state_nx;
			scan_vld_s1 <= do_scan;

			if (ld_supply) begin
				supply_q[cmd.row_index[ROW_W-1:0]] <= cmd.value;
			end
			if (ld_demand) begin
				demand_q[cmd.col_index[COL_W-1:0]] <= cmd.value;
			end
			if (ld_cost) begin
				cost_vld_q[cost_wa] <= 1'b1;
			end

			// restart the row-major scan at each pass
			if (do_restart) begin
				found_q    <= 1'b0;
				scan_idx_q <= '0;
				scan_row_q <= '0;
				scan_col_q <= '0;
			end else begin
				if (hit) begin
					found_q <= 1'b1;
				end
				if (do_scan && scan_idx_q != CELL_W'(NUM_CELLS - 1)) begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_col_q == COL_W'(NUM_SINKS - 1)) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + 1'b1;
					end else begin
						scan_col_q <= scan_col_q + 1'b1;
					end
				end
			end

			if (do_init) begin
				plan_vld_q <= '0;
				total_q    <= '0;
				emit_idx_q <= '0;
				emit_row_q <= '0;
				emit_col_q <= '0;
			end
			if (do_alloc) begin
				plan_vld_q[bk_q] <= 1'b1;
			end
			if (do_acc) begin
				total_q <= total_q + TOT_W'(prod_q);
			end

			// emit handshake: load, then hold until transfer
			if (do_emit_ld) begin
				emit_q <= E_WAIT;
			end else if (plan_xfer) begin
				emit_q <= E_NONE;
				if (!emit_last) begin
					emit_idx_q <= emit_idx_q + 1'b1;
					if (emit_col_q == COL_W'(NUM_SINKS - 1)) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + 1'b1;
					end else begin
						emit_col_q <= emit_col_q + 1'b1;
					end
				end
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q;
		scan_row_s1 <= scan_row_q;
		scan_col_s1 <= scan_col_q;

		if (do_restart) begin
			best_q <= COST_LIMIT;
		end else if (hit) begin
			best_q <= cost_use[LIM_W-1:0];
			br_q   <= scan_row_s1;
			bc_q   <= scan_col_s1;
			bk_q   <= scan_idx_s1;
		end

		if (do_init) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				rs_q[i] <= supply_q[i];
			end
			for (int j = 0; j < NUM_SINKS; j++) begin
				rd_q[j] <= demand_q[j];
			end
		end

		// one side of the chosen cell always drains to zero here
		if (do_alloc) begin
			rs_q[br_q] <= rs_sel - alloc_amt;
			rd_q[bc_q] <= rd_sel - alloc_amt;
			prod_q     <= PROD_W'(alloc_amt) * PROD_W'(best_q);
		end

		if (do_emit_ld) begin
			o_row_q  <= emit_row_q;
			o_col_q  <= emit_col_q;
			o_amt_q  <= plan_vld_q[emit_idx_q] ? plan_rd : '0;
			o_tot_q  <= emit_last ? total_q : '0;
			o_last_q <= emit_last;
		end
	end

	assign plan.out_row    = IDX_W'(o_row_q);
	assign plan.out_col    = IDX_W'(o_col_q);
	assign plan.amount     = o_amt_q;
	assign plan.total_cost = o_tot_q;
	assign plan.last       = o_last_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for least_cost_transport_plan_unit: loads, solves and plan-cell checks.
// Depends on lctp_pkg, lctp_if and the unit under test; nothing else.
`default_nettype none

module tb_top;
	import lctp_pkg::*;

	// Each solve streams 16 plan cells, and each cell may wait out an output stall.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 250;
	localparam int TARGET_ITEMS  = 470;

	typedef struct {
		idx_t out_row;
		idx_t out_col;
		val_t amount;
		tot_t total_cost;
		logic last;
	} plan_cell_t;

	logic clk = 1'b0;
	logic arst_n;

	lctp_cmd_if  cmd_ch ();
	lctp_plan_if plan_ch ();

	least_cost_transport_plan_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.plan   (plan_ch)
	);

	// Shadow copy of the loaded tables, updated on every accepted in-range load.
	val_t supply_amt [NUM_SOURCES];
	val_t demand_amt [NUM_SINKS];
	val_t unit_cost  [NUM_CELLS];

	// Plan cells still owed by the block, oldest first.
	plan_cell_t pending_cells[$];

	int error_count = 0;
	int item_count  = 0;
	int cycle_count = 0;
	// When set, both sides run without idle cycles.
	bit steady = 1'b0;

	always #5 clk = ~clk;

	// Watchdog: end the run once the cycle budget is spent.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("least_cost_transport_plan_unit verification failed");
		$finish;
	end

	// Build the least-cost plan from the shadow tables. Queue one cell per table entry,
	// in row-major order; the last cell carries the total.
	function automatic void predict_plan();
		val_t        left_supply [NUM_SOURCES];
		val_t        left_demand [NUM_SINKS];
		val_t        shipped     [NUM_CELLS];
		val_t        cheapest;
		val_t        moved;
		int          pick_r;
		int          pick_c;
		bit          found;
		logic [63:0] total;
		plan_cell_t  entry;

		left_supply = supply_amt;
		left_demand = demand_amt;
		foreach (shipped[k])
			shipped[k] = '0;
		do begin
			found    = 1'b0;
			cheapest = val_t'(COST_LIMIT);
			pick_r   = 0;
			pick_c   = 0;
			// A strict compare keeps the first cheapest cell in row-major order on a tie.
			for (int r = 0; r < NUM_SOURCES; r++)
				for (int c = 0; c < NUM_SINKS; c++)
					if (left_supply[r] != 0 && left_demand[c] != 0 &&
					    unit_cost[r*NUM_SINKS + c] < cheapest) begin
						cheapest = unit_cost[r*NUM_SINKS + c];
						pick_r   = r;
						pick_c   = c;
						found    = 1'b1;
					end
			if (found) begin
				moved = (left_supply[pick_r] < left_demand[pick_c]) ?
				        left_supply[pick_r] : left_demand[pick_c];
				shipped[pick_r*NUM_SINKS + pick_c] = moved;
				left_supply[pick_r] -= moved;
				left_demand[pick_c] -= moved;
			end
		end while (found);

		total = '0;
		foreach (shipped[k])
			total += 64'(shipped[k]) * 64'(unit_cost[k]);

		for (int k = 0; k < NUM_CELLS; k++) begin
			entry.out_row    = idx_t'(k / NUM_SINKS);
			entry.out_col    = idx_t'(k % NUM_SINKS);
			entry.amount     = shipped[k];
			entry.last       = (k == NUM_CELLS - 1);
			entry.total_cost = entry.last ? tot_t'(total) : '0;
			pending_cells.push_back(entry);
		end
	endfunction

	// Draw a supply or demand amount. Bias toward zero, the maximum and small values
	// so that remainders run out in many orders.
	function automatic val_t rand_amount();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return val_t'($urandom_range(1, 20));
			5, 6:    return val_t'($urandom_range(1, 1000));
			default: return val_t'($urandom);
		endcase
	endfunction

	// Draw a unit cost. Use tiny costs to get ties. Add cases around the cut-off and above it.
	function automatic val_t rand_cost();
		case ($urandom_range(0, 9))
			0, 1, 2: return val_t'($urandom_range(0, 3));
			3:       return val_t'(COST_LIMIT) - val_t'($urandom_range(0, 1));
			4:       return val_t'($urandom_range(int'(COST_LIMIT), (1 << VAL_W) - 1));
			5:       return '1;
			default: return val_t'($urandom_range(0, int'(COST_LIMIT) - 1));
		endcase
	endfunction

	// Present one command and hold it until the transfer.
	// Keep valid high when the next command follows with no gap.
	// On the transfer, update the shadow tables, or queue the plan on a solve.
	task automatic send_cmd(op_t op, idx_t row, idx_t col, val_t value);
		int gap;

		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.op        <= op;
		cmd_ch.row_index <= row;
		cmd_ch.col_index <= col;
		cmd_ch.value     <= value;
		do @(posedge clk); while (!cmd_ch.ready);

		case (op)
			OP_SUPPLY:
				if (row < NUM_SOURCES) begin
					supply_amt[row] = value;
					item_count++;
				end
			OP_DEMAND:
				if (col < NUM_SINKS) begin
					demand_amt[col] = value;
					item_count++;
				end
			OP_COST:
				if (row < NUM_SOURCES && col < NUM_SINKS) begin
					unit_cost[row*NUM_SINKS + col] = value;
					item_count++;
				end
			OP_SOLVE: begin
				predict_plan();
				item_count++;
			end
		endcase
	endtask

	// Drop valid and hold off until every queued plan cell has been seen.
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_cells.size() != 0);
	endtask

	function automatic idx_t any_idx();
		return idx_t'($urandom_range(0, 7));
	endfunction

	// Solve straight out of reset: all supply is zero, so no cell qualifies.
	task automatic test_empty_solve();
		send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
	endtask

	// Cover the maximum amounts, the costs on both sides of the cut-off, the maximum cost,
	// and loads with an index past the table (the block must ignore these).
	task automatic test_extremes();
		send_cmd(OP_SUPPLY, 3'd0, any_idx(), '1);
		send_cmd(OP_SUPPLY, 3'd3, any_idx(), val_t'(5));
		send_cmd(OP_DEMAND, any_idx(), 3'd0, '1);
		send_cmd(OP_DEMAND, any_idx(), 3'd3, val_t'(7));
		send_cmd(OP_SUPPLY, 3'd7, any_idx(), '1);
		send_cmd(OP_DEMAND, any_idx(), 3'd4, '1);
		send_cmd(OP_COST, 3'd5, 3'd1, val_t'(1));
		send_cmd(OP_COST, 3'd0, 3'd6, val_t'(1));
		send_cmd(OP_COST, 3'd0, 3'd0, val_t'(COST_LIMIT) - 1'b1);
		send_cmd(OP_COST, 3'd3, 3'd3, val_t'(COST_LIMIT));
		send_cmd(OP_COST, 3'd0, 3'd3, '1);
		send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
	endtask

	// Zero the supply again with nonzero costs loaded, so no cell qualifies.
	// Then open one row of zero-cost cells to force a tie.
	task automatic test_ties();
		send_cmd(OP_SUPPLY, 3'd0, any_idx(), '0);
		send_cmd(OP_SUPPLY, 3'd3, any_idx(), '0);
		send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
		send_cmd(OP_SUPPLY, 3'd1, any_idx(), val_t'(10));
		send_cmd(OP_DEMAND, any_idx(), 3'd0, '0);
		send_cmd(OP_DEMAND, any_idx(), 3'd1, val_t'(4));
		send_cmd(OP_DEMAND, any_idx(), 3'd2, val_t'(6));
		send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
	endtask

	// Let the block go fully idle between two solves of the same tables.
	task automatic test_drained_restart();
		send_cmd(OP_SUPPLY, 3'd2, any_idx(), rand_amount());
		send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
		wait_drained();
		send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
	endtask

	// Most rounds reload every table with random content and then solve.
	// Other rounds make a few scattered loads, some of them out of range,
	// or repeat a solve back to back.
	task automatic test_random_plans();
		int shape;
		int round;
		int loads;

		round = 0;
		while (item_count < TARGET_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			shape  = $urandom_range(0, 9);
			if (shape < 6) begin
				for (int r = 0; r < NUM_SOURCES; r++)
					send_cmd(OP_SUPPLY, idx_t'(r), any_idx(), rand_amount());
				for (int c = 0; c < NUM_SINKS; c++)
					send_cmd(OP_DEMAND, any_idx(), idx_t'(c), rand_amount());
				for (int k = 0; k < NUM_CELLS; k++)
					send_cmd(OP_COST, idx_t'(k / NUM_SINKS), idx_t'(k % NUM_SINKS),
					         rand_cost());
			end else if (shape < 9) begin
				loads = $urandom_range(1, 6);
				repeat (loads)
					send_cmd(op_t'($urandom_range(0, 2)), any_idx(), any_idx(),
					         ($urandom_range(0, 1) != 0) ? rand_amount() : rand_cost());
			end
			if (round % 4 == 3)
				wait_drained();
			send_cmd(OP_SOLVE, any_idx(), any_idx(), val_t'($urandom));
			round++;
		end
		steady = 1'b0;
	endtask

	// Plan checker: draw a stall before each transfer, then take one cell.
	// Compare it with the oldest expected cell.
	initial begin : plan_checker
		plan_cell_t want;
		int         stall;

		plan_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				plan_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			plan_ch.ready <= 1'b1;
			do @(posedge clk); while (plan_ch.valid !== 1'b1);

			if (pending_cells.size() == 0) begin
				$error("unexpected plan cell: row %0d col %0d amount %0d",
				       plan_ch.out_row, plan_ch.out_col, plan_ch.amount);
				error_count++;
			end else begin
				want = pending_cells.pop_front();
				if (plan_ch.out_row !== want.out_row) begin
					$error("out_row: expected %0d, got %0d", want.out_row, plan_ch.out_row);
					error_count++;
				end
				if (plan_ch.out_col !== want.out_col) begin
					$error("out_col: expected %0d, got %0d", want.out_col, plan_ch.out_col);
					error_count++;
				end
				if (plan_ch.amount !== want.amount) begin
					$error("amount: expected %0d, got %0d", want.amount, plan_ch.amount);
					error_count++;
				end
				if (plan_ch.total_cost !== want.total_cost) begin
					$error("total_cost: expected %0d, got %0d",
					       want.total_cost, plan_ch.total_cost);
					error_count++;
				end
				if (plan_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, plan_ch.last);
					error_count++;
				end
			end
		end
	end

	// Main sequence: reset, run the tests in turn, drain, then report.
	initial begin : main_sequence
		foreach (supply_amt[r])
			supply_amt[r] = '0;
		foreach (demand_amt[c])
			demand_amt[c] = '0;
		foreach (unit_cost[k])
			unit_cost[k] = '0;

		arst_n           <= 1'b0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.op        <= OP_SUPPLY;
		cmd_ch.row_index <= '0;
		cmd_ch.col_index <= '0;
		cmd_ch.value     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_solve();
		test_extremes();
		test_ties();
		test_drained_restart();
		test_random_plans();

		// Wait for every queued plan cell to arrive. Then keep watching for a stray solve.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_cells.size() == 0)
			$display("least_cost_transport_plan_unit verification clean");
		else
			$display("least_cost_transport_plan_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
